FILE: rtl/frws_pkg.sv
`default_nettype none

package frws_pkg;

  localparam int unsigned RATE_W     = 28;
  localparam int unsigned DUR_W      = 32;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 184;
  localparam int unsigned WINDOW     = 64;

  localparam logic [RATE_W-1:0] RATE_NUM = 28'd256000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE,
    ST_UPDATE,
    ST_FINISH
  } frws_state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic finish;
  } frws_cmd_t;

  typedef struct packed {
    logic rate_busy;
    logic out_full;
  } frws_status_t;

endpackage

`default_nettype wire

FILE: rtl/frws_ram.sv
`default_nettype none

module frws_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/frws_div.sv
`default_nettype none

module frws_div #(
  parameter int unsigned NW  = 29,
  parameter int unsigned QW  = 28,
  parameter int unsigned DVW = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [NW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                busy,
  output logic      [QW-1:0]  quotient
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic             busy_r;
  logic             busy_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [DVW-1:0]   rem_r;
  logic [DVW-1:0]   rem_nxt;
  logic [QW-1:0]    quo_r;
  logic [QW-1:0]    quo_nxt;
  logic [DVW-1:0]   div_r;
  logic [DVW:0]     trial;
  logic [DVW:0]     diff;
  logic             fits;

  // The upper part of the dividend is below the divisor, so only QW steps remain.
  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QW);
      rem_nxt  = DVW'(dividend[NW-1:QW]);
      quo_nxt  = dividend[QW-1:0];
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DVW-1:0] : trial[DVW-1:0];
      quo_nxt = {quo_r[QW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/frws_ctrl.sv
`default_nettype none

module frws_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire frws_pkg::frws_status_t status,
  output frws_pkg::frws_cmd_t         cmd
);

  import frws_pkg::*;

  frws_state_t state_r;
  frws_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_RATE;
        end
      end
      ST_RATE: begin
        if (!status.rate_busy) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !status.out_full;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !status.out_full)
    else $error("Result loaded while the output register is full.");

  a_update_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> !status.rate_busy)
    else $error("Sums updated while the divider is busy.");

  a_capture_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> status.rate_busy)
    else $error("Rate division did not start after a capture.");
`endif

endmodule

`default_nettype wire

FILE: rtl/frws_dp.sv
`default_nettype none

module frws_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire frws_pkg::frws_cmd_t                 cmd,
  output frws_pkg::frws_status_t                   status,
  input  wire logic [frws_pkg::DUR_W-1:0]          frame_us,
  input  wire logic                                out_tready,
  output logic                                     out_valid,
  output logic      [frws_pkg::RATE_W-1:0]         avg_rate,
  output logic      [frws_pkg::RATE_W-1:0]         min_rate,
  output logic      [frws_pkg::RATE_W-1:0]         max_rate,
  output logic      [frws_pkg::DUR_W-1:0]          avg_duration,
  output logic      [frws_pkg::DUR_W-1:0]          min_duration,
  output logic      [frws_pkg::DUR_W-1:0]          max_duration
);

  import frws_pkg::*;

  localparam int unsigned LW    = $clog2(WINDOW);
  localparam int unsigned RSW   = RATE_W + LW;
  localparam int unsigned DSW   = DUR_W + LW;
  localparam int unsigned RAM_W = RATE_W + DUR_W;

  logic [DUR_W-1:0]  dur_r;
  logic [DUR_W-1:0]  divisor;
  logic [RATE_W-1:0] rate_q;
  logic              rate_busy;
  logic [RAM_W-1:0]  rd_data;
  logic [RATE_W-1:0] old_rate;
  logic [DUR_W-1:0]  old_dur;
  logic [LW-1:0]     slot_r;
  logic              full_r;
  logic [RSW-1:0]    rsum_r;
  logic [RSW-1:0]    rsum_nxt;
  logic [DSW-1:0]    dsum_r;
  logic [DSW-1:0]    dsum_nxt;
  logic [RATE_W-1:0] avg_r_q;
  logic [DUR_W-1:0]  avg_d_q;
  logic [RATE_W-1:0] lo_rate_r;
  logic [RATE_W-1:0] hi_rate_r;
  logic [DUR_W-1:0]  lo_dur_r;
  logic [DUR_W-1:0]  hi_dur_r;
  logic [RATE_W-1:0] lo_rate_nxt;
  logic [RATE_W-1:0] hi_rate_nxt;
  logic [DUR_W-1:0]  lo_dur_nxt;
  logic [DUR_W-1:0]  hi_dur_nxt;
  logic              out_valid_r;
  logic [RATE_W-1:0] avg_rate_r;
  logic [RATE_W-1:0] min_rate_r;
  logic [RATE_W-1:0] max_rate_r;
  logic [DUR_W-1:0]  avg_dur_r;
  logic [DUR_W-1:0]  min_dur_r;
  logic [DUR_W-1:0]  max_dur_r;

  assign divisor = (frame_us == '0) ? DUR_W'(1) : frame_us;

  frws_div #(
    .NW  (RATE_W + 1),
    .QW  (RATE_W),
    .DVW (DUR_W)
  ) u_rate_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.capture),
    .dividend ({1'b0, RATE_NUM}),
    .divisor  (divisor),
    .busy     (rate_busy),
    .quotient (rate_q)
  );

  frws_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot_r),
    .wdata ({dur_r, rate_q}),
    .re    (cmd.capture),
    .raddr (slot_r),
    .rdata (rd_data)
  );

  // Slots are written in order, so before the first wrap the slot read is still unwritten.
  assign old_rate = full_r ? rd_data[RATE_W-1:0] : '0;
  assign old_dur  = full_r ? rd_data[RAM_W-1:RATE_W] : '0;

  assign rsum_nxt = rsum_r - RSW'(old_rate) + RSW'(rate_q);
  assign dsum_nxt = dsum_r - DSW'(old_dur) + DSW'(dur_r);

  // The window is a power of two, so each mean is its sum shifted right.
  assign avg_r_q = rsum_r[RSW-1:LW];
  assign avg_d_q = dsum_r[DSW-1:LW];

  assign lo_rate_nxt = (avg_r_q < lo_rate_r) ? avg_r_q : lo_rate_r;
  assign hi_rate_nxt = (avg_r_q > hi_rate_r) ? avg_r_q : hi_rate_r;
  assign lo_dur_nxt  = (avg_d_q < lo_dur_r) ? avg_d_q : lo_dur_r;
  assign hi_dur_nxt  = (avg_d_q > hi_dur_r) ? avg_d_q : hi_dur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      full_r      <= 1'b0;
      rsum_r      <= '0;
      dsum_r      <= '0;
      lo_rate_r   <= '1;
      hi_rate_r   <= '0;
      lo_dur_r    <= '1;
      hi_dur_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        rsum_r <= rsum_nxt;
        dsum_r <= dsum_nxt;
        if (slot_r == LW'(WINDOW - 1)) begin
          slot_r <= '0;
          full_r <= 1'b1;
        end else begin
          slot_r <= slot_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        lo_rate_r   <= lo_rate_nxt;
        hi_rate_r   <= hi_rate_nxt;
        lo_dur_r    <= lo_dur_nxt;
        hi_dur_r    <= hi_dur_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dur_r <= frame_us;
    end
    if (cmd.finish) begin
      avg_rate_r <= avg_r_q;
      min_rate_r <= lo_rate_nxt;
      max_rate_r <= hi_rate_nxt;
      avg_dur_r  <= avg_d_q;
      min_dur_r  <= lo_dur_nxt;
      max_dur_r  <= hi_dur_nxt;
    end
  end

  assign status.rate_busy = rate_busy;
  assign status.out_full  = out_valid_r;

  assign out_valid    = out_valid_r;
  assign avg_rate     = avg_rate_r;
  assign min_rate     = min_rate_r;
  assign max_rate     = max_rate_r;
  assign avg_duration = avg_dur_r;
  assign min_duration = min_dur_r;
  assign max_duration = max_dur_r;

`ifndef SYNTHESIS
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("Output not valid after a result was loaded.");

  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (min_rate_r <= avg_rate_r && avg_rate_r <= max_rate_r &&
                     min_dur_r <= avg_dur_r && avg_dur_r <= max_dur_r))
    else $error("Reported mean lies outside its minimum and maximum.");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LW'(WINDOW - 1))
    else $error("Ring slot beyond the window.");
`endif

endmodule

`default_nettype wire

FILE: rtl/frame_rate_window_stats_core.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       slave      in_tvalid/tready    frame_us
// out_      master     out_tvalid/tready   avg/min/max rate, avg/min/max duration
//
// An item passes through these steps in order: acceptance, which starts the rate
// division; the 28 steps of the division, until the divider reports done; the update
// of the ring and the running sums; and the load of the result, which raises out_tvalid.
// The ring is one RAM of WINDOW slots; slots not yet written read as zero until the
// write pointer first wraps, so reset needs no clearing pass.
// A new item is taken while the previous result still waits in the output register.
// A result that finds the output register full holds the block until it is taken.
module frame_rate_window_stats_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // frame_us[31:0]
  input  wire logic [frws_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // avg_rate[27:0], min_rate[55:28], max_rate[83:56], avg_duration[115:84],
  // min_duration[147:116], max_duration[179:148], zero[183:180]
  output logic      [frws_pkg::OUT_DATA_W-1:0]   out_tdata
);

  import frws_pkg::*;

  frws_cmd_t         cmd;
  frws_status_t      status;
  logic [RATE_W-1:0] avg_rate;
  logic [RATE_W-1:0] min_rate;
  logic [RATE_W-1:0] max_rate;
  logic [DUR_W-1:0]  avg_duration;
  logic [DUR_W-1:0]  min_duration;
  logic [DUR_W-1:0]  max_duration;

  frws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  frws_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .frame_us     (in_tdata[DUR_W-1:0]),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .avg_rate     (avg_rate),
    .min_rate     (min_rate),
    .max_rate     (max_rate),
    .avg_duration (avg_duration),
    .min_duration (min_duration),
    .max_duration (max_duration)
  );

  assign out_tdata = {4'b0000, max_duration, min_duration, avg_duration,
                      max_rate, min_rate, avg_rate};

endmodule

`default_nettype wire
